// File: sv/cfsw_pkg.sv
// Shared types and constants for the call frame stack write monitor.
`default_nettype none

package cfsw_pkg;

    localparam int STACK_DEPTH_DEFAULT = 16;

    localparam logic [1:0] REQ_CALL        = 2'd0;
    localparam logic [1:0] REQ_BLOCK_START = 2'd1;
    localparam logic [1:0] REQ_BLOCK_END   = 2'd2;
    localparam logic [1:0] REQ_WRITE       = 2'd3;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [31:0] pc_value;
        logic [31:0] stack_pointer;
        logic        is_return_block;
        logic [31:0] address;
        logic [3:0]  write_size;
    } in_t;

    typedef struct packed {
        logic        corruption_detected;
        logic [31:0] write_frame;
        logic [31:0] previous_address;
        logic [31:0] previous_frame;
        logic [4:0]  frame_count;
        logic        overflow;
    } out_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic capture;
        logic walk;
        logic commit;
    } ctrl_cmd_t;

    typedef struct packed {
        logic in_is_write;
        logic depth_zero;
        logic walk_done;
    } dp_status_t;

endpackage

`default_nettype wire

// File: sv/cfsw_datapath.sv
// Datapath: frame memory, frame walk, write tracking state and result register.
`default_nettype none

module cfsw_datapath #(
    parameter int STACK_DEPTH = cfsw_pkg::STACK_DEPTH_DEFAULT
) (
    input  wire                     aclk,
    input  wire                     aresetn,
    input  wire cfsw_pkg::in_t      s_data,
    input  wire cfsw_pkg::ctrl_cmd_t cmd,
    output cfsw_pkg::dp_status_t    status,
    output cfsw_pkg::out_t          m_data
);

    localparam int IDXW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int DW   = $clog2(STACK_DEPTH + 1);

    logic [31:0]     mem [STACK_DEPTH];
    logic [31:0]     rd_data_reg;
    logic [IDXW-1:0] rd_idx;

    cfsw_pkg::in_t   item_reg;
    cfsw_pkg::out_t  out_reg;
    logic [IDXW-1:0] idx_reg,   idx_next;
    logic [31:0]     found_reg, found_next;
    logic [DW-1:0]   depth_reg, depth_next;
    logic            armed_reg, armed_next;
    logic [31:0]     bspc_reg,  bspc_next;
    logic [31:0]     laddr_reg, laddr_next;
    logic [3:0]      lsize_reg, lsize_next;
    logic [31:0]     lframe_reg, lframe_next;

    logic            hit;
    logic            at_last;
    logic            push;
    logic            overflow;
    logic            corrupt;
    logic [31:0]     cont_addr;

    // frame walk
    assign hit     = item_reg.address > rd_data_reg;
    assign at_last = DW'(idx_reg) == (depth_reg - DW'(1));

    assign status.in_is_write = s_data.req_type == cfsw_pkg::REQ_WRITE;
    assign status.depth_zero  = depth_reg == '0;
    assign status.walk_done   = hit || at_last;

    always_comb begin
        if (cmd.capture) begin
            rd_idx = '0;
        end else if (idx_reg == IDXW'(STACK_DEPTH - 1)) begin
            rd_idx = '0;
        end else begin
            rd_idx = idx_reg + IDXW'(1);
        end
    end

    always_comb begin
        idx_next   = idx_reg;
        found_next = found_reg;
        if (cmd.capture) begin
            idx_next   = '0;
            found_next = '0;
        end else if (cmd.walk) begin
            if (status.walk_done) begin
                found_next = (hit && idx_reg != '0) ? rd_data_reg : 32'd0;
            end else begin
                idx_next = idx_reg + IDXW'(1);
            end
        end
    end

    // state update at commit
    assign cont_addr = 32'(laddr_reg + 32'(lsize_reg));
    assign corrupt   = (item_reg.req_type == cfsw_pkg::REQ_WRITE) && (depth_reg > DW'(1))
                       && (found_reg != '0) && (lframe_reg != '0)
                       && (cont_addr == item_reg.address) && (found_reg != lframe_reg);
    assign push      = cmd.commit && (item_reg.req_type == cfsw_pkg::REQ_CALL)
                       && (depth_reg < DW'(STACK_DEPTH));
    assign overflow  = (item_reg.req_type == cfsw_pkg::REQ_CALL)
                       && (depth_reg >= DW'(STACK_DEPTH));

    always_comb begin
        depth_next  = depth_reg;
        armed_next  = armed_reg;
        bspc_next   = bspc_reg;
        laddr_next  = laddr_reg;
        lsize_next  = lsize_reg;
        lframe_next = lframe_reg;
        unique case (item_reg.req_type)
            cfsw_pkg::REQ_CALL: begin
                if (!overflow) begin
                    depth_next = depth_reg + DW'(1);
                end
            end
            cfsw_pkg::REQ_BLOCK_START: begin
                bspc_next = item_reg.pc_value;
                if (item_reg.is_return_block) begin
                    armed_next = 1'b1;
                end
            end
            cfsw_pkg::REQ_BLOCK_END: begin
                if (armed_reg) begin
                    armed_next = 1'b0;
                    if (bspc_reg != item_reg.pc_value && depth_reg != '0) begin
                        depth_next = depth_reg - DW'(1);
                    end
                end
            end
            cfsw_pkg::REQ_WRITE: begin
                if (!corrupt) begin
                    laddr_next  = item_reg.address;
                    lsize_next  = item_reg.write_size;
                    lframe_next = found_reg;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        rd_data_reg <= mem[rd_idx];
        if (push) begin
            mem[depth_reg[IDXW-1:0]] <= item_reg.stack_pointer;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            item_reg <= s_data;
        end
        idx_reg   <= idx_next;
        found_reg <= found_next;
        if (cmd.commit) begin
            out_reg.corruption_detected <= corrupt;
            out_reg.write_frame         <= found_reg;
            out_reg.previous_address    <= laddr_next;
            out_reg.previous_frame      <= lframe_next;
            out_reg.frame_count         <= 5'(depth_next);
            out_reg.overflow            <= overflow;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            depth_reg  <= '0;
            armed_reg  <= 1'b0;
            bspc_reg   <= '0;
            laddr_reg  <= '0;
            lsize_reg  <= '0;
            lframe_reg <= '0;
        end else if (cmd.commit) begin
            depth_reg  <= depth_next;
            armed_reg  <= armed_next;
            bspc_reg   <= bspc_next;
            laddr_reg  <= laddr_next;
            lsize_reg  <= lsize_next;
            lframe_reg <= lframe_next;
        end
    end

    assign m_data = out_reg;

`ifndef ASSERT_OFF
    a_depth_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        depth_reg <= DW'(STACK_DEPTH))
        else $error("frame depth beyond stack size");

    a_walk_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.walk |-> (DW'(idx_reg) < depth_reg))
        else $error("frame walk past top of stack");

    a_corrupt_keeps_record: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.commit && corrupt) |=> $stable(laddr_reg) && $stable(lframe_reg))
        else $error("write record changed on corruption");
`endif

endmodule

`default_nettype wire

// File: sv/cfsw_ctrl.sv
// Controller: sequences capture, frame walk and commit, owns the output valid.
`default_nettype none

module cfsw_ctrl (
    input  wire                      aclk,
    input  wire                      aresetn,
    input  wire                      s_valid,
    output logic                     s_ready,
    output logic                     m_valid,
    input  wire                      m_ready,
    input  wire cfsw_pkg::dp_status_t status,
    output cfsw_pkg::ctrl_cmd_t      cmd
);

    cfsw_pkg::state_t state_reg, state_next;
    logic             m_valid_reg, m_valid_next;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            cfsw_pkg::ST_IDLE: begin
                if (s_valid) begin
                    if (status.in_is_write && !status.depth_zero) begin
                        state_next = cfsw_pkg::ST_WALK;
                    end else begin
                        state_next = cfsw_pkg::ST_FINISH;
                    end
                end
            end
            cfsw_pkg::ST_WALK: begin
                if (status.walk_done) begin
                    state_next = cfsw_pkg::ST_FINISH;
                end
            end
            cfsw_pkg::ST_FINISH: begin
                if (!m_valid_reg || m_ready) begin
                    state_next = cfsw_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = cfsw_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        s_ready     = 1'b0;
        cmd.capture = 1'b0;
        cmd.walk    = 1'b0;
        cmd.commit  = 1'b0;
        unique case (state_reg)
            cfsw_pkg::ST_IDLE: begin
                s_ready     = 1'b1;
                cmd.capture = s_valid;
            end
            cfsw_pkg::ST_WALK: begin
                cmd.walk = 1'b1;
            end
            cfsw_pkg::ST_FINISH: begin
                cmd.commit = !m_valid_reg || m_ready;
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        if (cmd.commit) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= cfsw_pkg::ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_valid = m_valid_reg;

`ifndef ASSERT_OFF
    a_walk_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == cfsw_pkg::ST_WALK) |-> !status.depth_zero)
        else $error("frame walk on empty stack");

    a_valid_from_commit: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == cfsw_pkg::ST_FINISH))
        else $error("result raised outside finish");

    a_nonwrite_direct: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.capture && !status.in_is_write) |=> (state_reg == cfsw_pkg::ST_FINISH))
        else $error("non-write transaction entered walk");
`endif

endmodule

`default_nettype wire

// File: sv/call_frame_stack_write_monitor.sv
// Top level of the call frame stack write monitor.
//
//  port group   dir   handshake           payload
//  s_*          in    s_valid / s_ready   s_data  (cfsw_pkg::in_t)
//  m_*          out   m_valid / m_ready   m_data  (cfsw_pkg::out_t)
//
// Call, block start and block end transactions pass from capture straight to commit.
// A write transaction walks the frames between capture and commit and compares k
// of them (0 on an empty stack, else 1..STACK_DEPTH), one entry per cycle.
// Reset (aresetn low) empties the stack and clears the write record.
// Results wait in an output register; a new transaction is taken meanwhile,
// and its commit stalls only until the waiting result is taken.
`default_nettype none

module call_frame_stack_write_monitor #(
    parameter int STACK_DEPTH = cfsw_pkg::STACK_DEPTH_DEFAULT
) (
    input  wire                 aclk,
    input  wire                 aresetn,
    input  wire                 s_valid,
    output logic                s_ready,
    input  wire cfsw_pkg::in_t  s_data,
    output logic                m_valid,
    input  wire                 m_ready,
    output cfsw_pkg::out_t      m_data
);

    cfsw_pkg::ctrl_cmd_t  cmd;
    cfsw_pkg::dp_status_t status;

    cfsw_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .status  (status),
        .cmd     (cmd)
    );

    cfsw_datapath #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_datapath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_data  (s_data),
        .cmd     (cmd),
        .status  (status),
        .m_data  (m_data)
    );

endmodule

`default_nettype wire
